[hw/rtl/falru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_pkg
// Shared sizes and types for the fully associative LRU tag store.
// ----------------------------------------------------------------------------
package falru_pkg;

    localparam int ENTRIES   = 4;
    localparam int ADDR_BITS = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // fixed port widths
    localparam int IN_ADDR_W = 16;
    localparam int SLOT_W    = 2;
    localparam int EVICT_W   = 16;

    localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(ENTRIES - 1);

    typedef logic [ADDR_BITS-1:0] t_tag;
    typedef logic [IDX_W-1:0]     t_idx;

    // search results rippling down the row of cells
    typedef struct packed {
        logic hit;
        t_idx hit_idx;
        t_idx hit_rank;
        logic empty;
        t_idx empty_idx;
        t_idx empty_rank;
        logic lru;
        t_idx lru_idx;
        t_tag lru_tag;
    } t_chain;

    // update broadcast to every cell
    typedef struct packed {
        logic en;
        logic write;
        t_idx slot;
        t_idx rank;
        t_tag addr;
    } t_upd;

endpackage

[hw/rtl/falru_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_cell
// One slot: tag, valid bit and recency rank; adds its match, empty and
// LRU status to the search chain and applies broadcast updates.
// ----------------------------------------------------------------------------
module falru_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  falru_pkg::t_idx      i_idx,
    input  falru_pkg::t_tag      i_addr,
    input  falru_pkg::t_chain    i_chain,
    output falru_pkg::t_chain    o_chain,
    input  falru_pkg::t_upd      i_upd
);
    import falru_pkg::*;

    t_tag r_tag;
    logic r_valid;
    t_idx r_rank;

    logic hit_here;
    logic empty_here;
    logic lru_here;

    assign hit_here   = r_valid && (r_tag == i_addr);
    assign empty_here = !r_valid;
    assign lru_here   = (r_rank == LRU_RANK);

    // first match wins, so earlier cells keep priority
    always_comb begin
        o_chain = i_chain;
        if (!i_chain.hit && hit_here) begin
            o_chain.hit      = 1'b1;
            o_chain.hit_idx  = i_idx;
            o_chain.hit_rank = r_rank;
        end
        if (!i_chain.empty && empty_here) begin
            o_chain.empty      = 1'b1;
            o_chain.empty_idx  = i_idx;
            o_chain.empty_rank = r_rank;
        end
        if (!i_chain.lru && lru_here) begin
            o_chain.lru     = 1'b1;
            o_chain.lru_idx = i_idx;
            o_chain.lru_tag = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= i_idx;
        end else if (i_upd.en) begin
            if (i_upd.slot == i_idx) begin
                r_rank <= '0;
                if (i_upd.write) begin
                    r_valid <= 1'b1;
                end
            end else if (r_rank < i_upd.rank) begin
                r_rank <= r_rank + t_idx'(1);
            end
        end
    end

    // tag store: no reset, only read while valid
    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.write && (i_upd.slot == i_idx)) begin
            r_tag <= i_upd.addr;
        end
    end

endmodule

[hw/rtl/fully_assoc_lru_tag_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_store
// Fully associative tag store with true LRU replacement.
// ----------------------------------------------------------------------------
// Each item is one block address. It goes through an accept, a lookup
// and an update step: the accept step registers the address, the
// lookup step ripples match / first-empty / LRU search through the row
// of slot cells and registers the decision, and the update step writes
// the tag, moves the ranks and loads the result register. A new item is
// taken once back in idle, after the last one has left its update step;
// the result register lets the next item start while a result still
// waits. On a hit, hit=1 and nothing is evicted. On a miss the lowest
// empty slot is filled, or when all are full the LRU slot is replaced
// and its old address reported with evicted_valid=1. After reset all
// slots are empty and no clearing pass is needed.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [falru_pkg::IN_ADDR_W-1:0]     i_block_address,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [falru_pkg::SLOT_W-1:0]        o_slot,
    output logic                                o_evicted_valid,
    output logic [falru_pkg::EVICT_W-1:0]       o_evicted_address
);
    import falru_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

    t_state r_state;
    t_tag   r_addr;

    // registered decision from the lookup cycle
    logic r_hit;
    logic r_write;
    t_idx r_slot;
    t_idx r_rank;
    logic r_evv;
    t_tag r_eva;

    // result register
    logic r_o_valid;
    logic r_o_hit;
    t_idx r_o_slot;
    logic r_o_evv;
    t_tag r_o_eva;

    t_chain chain [ENTRIES+1];
    t_upd   upd;
    t_chain fin;
    logic   out_free;

    assign chain[0] = '0;
    assign fin      = chain[ENTRIES];
    assign out_free = !r_o_valid || !i_stall;

    assign upd.en    = (r_state == S_UPD) && out_free;
    assign upd.write = r_write;
    assign upd.slot  = r_slot;
    assign upd.rank  = r_rank;
    assign upd.addr  = r_addr;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        falru_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_addr  (r_addr),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .i_upd   (upd)
        );
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_hit             = r_o_hit;
    assign o_slot            = SLOT_W'(r_o_slot);
    assign o_evicted_valid   = r_o_evv;
    assign o_evicted_address = EVICT_W'(r_o_eva);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if (r_state == S_UPD && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_addr  <= ADDR_BITS'(i_block_address);
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // hit, else first empty slot, else the LRU slot
                    r_hit <= fin.hit;
                    r_evv <= 1'b0;
                    r_eva <= '0;
                    if (fin.hit) begin
                        r_write <= 1'b0;
                        r_slot  <= fin.hit_idx;
                        r_rank  <= fin.hit_rank;
                    end else if (fin.empty) begin
                        r_write <= 1'b1;
                        r_slot  <= fin.empty_idx;
                        r_rank  <= fin.empty_rank;
                    end else begin
                        r_write <= 1'b1;
                        r_slot  <= fin.lru_idx;
                        r_rank  <= LRU_RANK;
                        r_evv   <= 1'b1;
                        r_eva   <= fin.lru_tag;
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_o_hit   <= r_hit;
                        r_o_slot  <= r_slot;
                        r_o_evv   <= r_evv;
                        r_o_eva   <= r_eva;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // the ranks always hold the max rank somewhere
    a_lru_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> fin.lru)
        else $error("no slot holds the LRU rank");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_hit) |-> (!r_evv && !r_write))
        else $error("hit marked as eviction or fill");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && !fin.hit) |=> (r_evv == !$past(fin.empty)))
        else $error("eviction while an empty slot exists");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && r_state == S_LOOK))
        else $error("accepted item not in lookup");
`endif

endmodule
